>>> rtl/rk4o_pkg.sv
// Shared types, constants and helpers of the RK4 oscillator step unit.
package rk4o_pkg;

  // Word format: signed fixed point with FRAC_BITS fraction bits.
  localparam int W         = 48;
  localparam int FRAC_BITS = 32;
  localparam int H_W       = FRAC_BITS + 1;
  localparam int PROD_W    = 2 * W;
  localparam int TDATA_W   = 2 * W;

  // Wide sums keep four guard bits, enough for k1 + 2*k2 + 2*k3 + k4 plus a bias.
  localparam int SUM_W     = W + 4;

  // Step size after reset, about 0.0001.
  localparam logic [H_W-1:0] H_RESET = H_W'(429497);

  typedef logic signed [W-1:0]     word_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam word_t W_MAX = {1'b0, {(W-1){1'b1}}};
  localparam word_t W_MIN = {1'b1, {(W-1){1'b0}}};

  // The weighted sums start at 6 * 2^(W-1) so the divider sees a nonnegative value.
  localparam logic [SUM_W-1:0] SUM_BIAS  = SUM_W'(3) << W;
  // Quotient of that bias by six, removed again after division.
  localparam logic [SUM_W-1:0] QUOT_BIAS = SUM_W'(1) << (W - 1);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_DRIVE,
    CFG_STIFF,
    CFG_DAMP,
    CFG_STEP
  } cfg_idx_e;

  // Multiplier request and response.
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    logic  clip;
    word_t res;
  } mul_rsp_t;

  // Divide-by-six request and response, two lanes.
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] u_pos;
    logic [SUM_W-1:0] u_vel;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] q_pos;
    logic [SUM_W-1:0] q_vel;
  } div_rsp_t;

  typedef struct packed {
    logic  clip;
    word_t val;
  } sat_t;

  // Sign-extend a word to the wide sum format.
  function automatic sum_t sx(input word_t x);
    return {{(SUM_W-W){x[W-1]}}, x};
  endfunction

  // Clip a wide sum to the word range and flag whether it clipped.
  function automatic sat_t sat_word(input sum_t v);
    sat_t r;
    r.clip = 1'b0;
    r.val  = v[W-1:0];
    if (!((&v[SUM_W-1:W-1]) || !(|v[SUM_W-1:W-1]))) begin
      r.clip = 1'b1;
      r.val  = v[SUM_W-1] ? W_MIN : W_MAX;
    end
    return r;
  endfunction

endpackage

>>> rtl/rk4_damped_oscillator_step_unit.sv
// Channel   Direction  tdata (low bit first)                 tuser
// s_axis    in         load_position[47:0], load_velocity    kind (0 load, 1 step)
// m_axis    out        position[47:0], velocity              saturated
// cfg       in         write enable, index, 48-bit data      -
//
// A load item is written into the position and velocity registers at its accepting edge and
// passes on to the output register once that is free. A step item runs sixteen products
// through the shared multiplier and then a divide by six before its result moves on to the
// output register. The input is ready whenever the sequencer is idle; a finished
// result waits in the sequencer while the output register still holds the previous one.
// Reset clears position, velocity and coefficients and sets the step size to about 0.0001.
module rk4_damped_oscillator_step_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rk4o_pkg::TDATA_W-1:0]   s_axis_tdata,   // load_position, load_velocity
  input  logic                           s_axis_tuser,   // kind
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rk4o_pkg::TDATA_W-1:0]   m_axis_tdata,   // position, velocity
  output logic                           m_axis_tuser,   // saturated
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [rk4o_pkg::W-1:0]         cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_MUL,
    ST_FSUM,
    ST_NEXT,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    OP_K,
    OP_CZ,
    OP_BY,
    OP_L
  } op_e;

  localparam int W = rk4o_pkg::W;

  // Configuration registers.
  rk4o_pkg::word_t          drive_q, stiff_q, damp_q;
  logic [rk4o_pkg::H_W-1:0] h_q;

  // Sequencer state and results.
  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [1:0]         stage_q, stage_d;
  logic               sat_q, sat_d;
  rk4o_pkg::word_t    pos_q, pos_d, vel_q, vel_d;
  rk4o_pkg::mul_req_t mreq_q, mreq_d;
  rk4o_pkg::mul_rsp_t mrsp;
  rk4o_pkg::div_req_t dreq_q, dreq_d;
  rk4o_pkg::div_rsp_t drsp;

  // Stage datapath.
  rk4o_pkg::word_t    ya_q, ya_d, za_q, za_d, k_q, k_d, l_q, l_d;
  rk4o_pkg::word_t    cz_q, cz_d, by_q, by_d, f_q, f_d;
  rk4o_pkg::sum_t     sumk_q, sumk_d, suml_q, suml_d;
  rk4o_pkg::word_t    h_word;

  // Output register.
  logic               out_valid_q;
  rk4o_pkg::word_t    out_pos_q, out_vel_q;
  logic               out_sat_q;
  logic               out_load;

  logic s_fire;
  logic m_fire;

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign m_fire   = m_axis_tvalid && m_axis_tready;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_fire);
  assign h_word   = {{(W-rk4o_pkg::H_W){1'b0}}, h_q};

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q <= '0;
      stiff_q <= '0;
      damp_q  <= '0;
      h_q     <= rk4o_pkg::H_RESET;
    end else if (cfg_we_i) begin
      case (rk4o_pkg::cfg_idx_e'(cfg_idx_i))
        rk4o_pkg::CFG_DRIVE: drive_q <= cfg_data_i;
        rk4o_pkg::CFG_STIFF: stiff_q <= cfg_data_i;
        rk4o_pkg::CFG_DAMP:  damp_q  <= cfg_data_i;
        rk4o_pkg::CFG_STEP:  h_q     <= cfg_data_i[rk4o_pkg::H_W-1:0];
        default:             h_q     <= h_q;
      endcase
    end
  end

  // Shared multiplier and divider.
  rk4o_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq_q),
    .rsp_o  (mrsp)
  );

  rk4o_div6 u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq_q),
    .rsp_o  (drsp)
  );

  // Sequencer: per stage k = h*z, c*z, b*y, f = a - c*z - b*y, l = h*f,
  // then the next stage arguments and the weighted sums.
  always_comb begin
    rk4o_pkg::sat_t s_a;
    rk4o_pkg::sat_t s_b;
    rk4o_pkg::sum_t kx;
    rk4o_pkg::sum_t lx;

    state_d = state_q;
    op_d    = op_q;
    stage_d = stage_q;
    sat_d   = sat_q;
    pos_d   = pos_q;
    vel_d   = vel_q;
    mreq_d  = mreq_q;
    mreq_d.start = 1'b0;
    dreq_d  = dreq_q;
    dreq_d.start = 1'b0;
    ya_d    = ya_q;
    za_d    = za_q;
    k_d     = k_q;
    l_d     = l_q;
    cz_d    = cz_q;
    by_d    = by_q;
    f_d     = f_q;
    sumk_d  = sumk_q;
    suml_d  = suml_q;
    s_a     = '0;
    s_b     = '0;
    kx      = rk4o_pkg::sx(k_q);
    lx      = rk4o_pkg::sx(l_q);

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          sat_d = 1'b0;
          if (s_axis_tuser) begin
            ya_d    = pos_q;
            za_d    = vel_q;
            stage_d = '0;
            op_d    = OP_K;
            sumk_d  = rk4o_pkg::SUM_BIAS;
            suml_d  = rk4o_pkg::SUM_BIAS;
            state_d = ST_ISSUE;
          end else begin
            pos_d   = s_axis_tdata[W-1:0];
            vel_d   = s_axis_tdata[2*W-1:W];
            state_d = ST_OUT;
          end
        end
      end

      ST_ISSUE: begin
        mreq_d.start = 1'b1;
        case (op_q)
          OP_K: begin
            mreq_d.a = h_word;
            mreq_d.b = za_q;
          end
          OP_CZ: begin
            mreq_d.a = damp_q;
            mreq_d.b = za_q;
          end
          OP_BY: begin
            mreq_d.a = stiff_q;
            mreq_d.b = ya_q;
          end
          default: begin
            mreq_d.a = h_word;
            mreq_d.b = f_q;
          end
        endcase
        state_d = ST_MUL;
      end

      ST_MUL: begin
        if (mrsp.done) begin
          sat_d = sat_q | mrsp.clip;
          case (op_q)
            OP_K: begin
              k_d     = mrsp.res;
              op_d    = OP_CZ;
              state_d = ST_ISSUE;
            end
            OP_CZ: begin
              cz_d    = mrsp.res;
              op_d    = OP_BY;
              state_d = ST_ISSUE;
            end
            OP_BY: begin
              by_d    = mrsp.res;
              state_d = ST_FSUM;
            end
            default: begin
              l_d     = mrsp.res;
              state_d = ST_NEXT;
            end
          endcase
        end
      end

      // Acceleration, summed exactly and clipped once.
      ST_FSUM: begin
        s_a = rk4o_pkg::sat_word(rk4o_pkg::sx(drive_q) - rk4o_pkg::sx(cz_q)
                                 - rk4o_pkg::sx(by_q));
        f_d     = s_a.val;
        sat_d   = sat_q | s_a.clip;
        op_d    = OP_L;
        state_d = ST_ISSUE;
      end

      // Weighted sums; the middle two stages count twice.
      ST_NEXT: begin
        if (stage_q == 2'd1 || stage_q == 2'd2) begin
          sumk_d = sumk_q + (kx <<< 1);
          suml_d = suml_q + (lx <<< 1);
        end else begin
          sumk_d = sumk_q + kx;
          suml_d = suml_q + lx;
        end
        if (stage_q == 2'd3) begin
          dreq_d.start = 1'b1;
          dreq_d.u_pos = sumk_d;
          dreq_d.u_vel = suml_d;
          state_d      = ST_DIV;
        end else begin
          if (stage_q == 2'd2) begin
            s_a = rk4o_pkg::sat_word(rk4o_pkg::sx(pos_q) + kx);
            s_b = rk4o_pkg::sat_word(rk4o_pkg::sx(vel_q) + lx);
          end else begin
            s_a = rk4o_pkg::sat_word(rk4o_pkg::sx(pos_q) + (kx >>> 1));
            s_b = rk4o_pkg::sat_word(rk4o_pkg::sx(vel_q) + (lx >>> 1));
          end
          ya_d    = s_a.val;
          za_d    = s_b.val;
          sat_d   = sat_q | s_a.clip | s_b.clip;
          stage_d = stage_q + 2'd1;
          op_d    = OP_K;
          state_d = ST_ISSUE;
        end
      end

      // New state: old value plus the sixth of the weighted sum, bias removed.
      ST_DIV: begin
        if (drsp.done) begin
          s_a = rk4o_pkg::sat_word(rk4o_pkg::sx(pos_q) + $signed(drsp.q_pos)
                                   - $signed(rk4o_pkg::QUOT_BIAS));
          s_b = rk4o_pkg::sat_word(rk4o_pkg::sx(vel_q) + $signed(drsp.q_vel)
                                   - $signed(rk4o_pkg::QUOT_BIAS));
          pos_d   = s_a.val;
          vel_d   = s_b.val;
          sat_d   = sat_q | s_a.clip | s_b.clip;
          state_d = ST_OUT;
        end
      end

      // Hand the result to the output register once it is free.
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, results and unit requests.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_K;
      stage_q <= '0;
      sat_q   <= 1'b0;
      pos_q   <= '0;
      vel_q   <= '0;
      mreq_q  <= '0;
      dreq_q  <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      stage_q <= stage_d;
      sat_q   <= sat_d;
      pos_q   <= pos_d;
      vel_q   <= vel_d;
      mreq_q  <= mreq_d;
      dreq_q  <= dreq_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ya_q   <= ya_d;
    za_q   <= za_d;
    k_q    <= k_d;
    l_q    <= l_d;
    cz_q   <= cz_d;
    by_q   <= by_d;
    f_q    <= f_d;
    sumk_q <= sumk_d;
    suml_q <= suml_d;
  end

  // Output register: filled from the sequencer, emptied by an output transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_pos_q   <= '0;
      out_vel_q   <= '0;
      out_sat_q   <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
      out_pos_q   <= pos_q;
      out_vel_q   <= vel_q;
      out_sat_q   <= sat_q;
    end else if (m_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Stream ports.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_vel_q, out_pos_q};
  assign m_axis_tuser  = out_sat_q;

endmodule

>>> rtl/rk4o_mul.sv
// Sequential signed fixed-point multiplier: four 25x25 partial products, one per cycle,
// accumulated into the exact product, then scaled and clipped to the word range.
module rk4o_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rk4o_pkg::mul_req_t req_i,
  output rk4o_pkg::mul_rsp_t rsp_o
);

  localparam int HALF_W = rk4o_pkg::W / 2;
  localparam int PART_W = HALF_W + 1;
  localparam int PP_W   = 2 * PART_W;
  localparam int PARTS  = 4;

  logic                                busy_q;
  logic [2:0]                          cnt_q;
  logic                                done_q;
  rk4o_pkg::word_t                     a_q, b_q;
  logic signed [PP_W-1:0]              pp_q, pp_d;
  logic [1:0]                          psel_q;
  logic signed [rk4o_pkg::PROD_W-1:0]  acc_q;
  logic signed [rk4o_pkg::PROD_W-1:0]  addend;
  logic signed [rk4o_pkg::PROD_W-1:0]  scaled;
  logic signed [PART_W-1:0]            x, y;
  logic [rk4o_pkg::PROD_W-rk4o_pkg::W:0] top;

  // Low halves are unsigned, high halves carry the sign.
  function automatic logic signed [PART_W-1:0] lo_part(input rk4o_pkg::word_t v);
    return {1'b0, v[HALF_W-1:0]};
  endfunction

  function automatic logic signed [PART_W-1:0] hi_part(input rk4o_pkg::word_t v);
    return {v[rk4o_pkg::W-1], v[rk4o_pkg::W-1:HALF_W]};
  endfunction

  // Partial product selection for this cycle.
  always_comb begin
    case (cnt_q)
      3'd0: begin
        x = lo_part(a_q);
        y = lo_part(b_q);
      end
      3'd1: begin
        x = lo_part(a_q);
        y = hi_part(b_q);
      end
      3'd2: begin
        x = hi_part(a_q);
        y = lo_part(b_q);
      end
      default: begin
        x = hi_part(a_q);
        y = hi_part(b_q);
      end
    endcase
    pp_d = x * y;
  end

  // Align the registered partial product to its weight.
  always_comb begin
    addend = {{(rk4o_pkg::PROD_W-PP_W){pp_q[PP_W-1]}}, pp_q};
    case (psel_q)
      2'd0:    addend = addend;
      2'd3:    addend = addend <<< rk4o_pkg::W;
      default: addend = addend <<< HALF_W;
    endcase
  end

  // Control: latch on start, run the partial products, pulse done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'(PARTS)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the partial product is registered, then added to the accumulator in the next cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      pp_q   <= pp_d;
      psel_q <= cnt_q[1:0];
      if (cnt_q != 3'd0) begin
        acc_q <= acc_q + addend;
      end
    end
  end

  // Drop the fraction bits with floor rounding and clip to the word range.
  always_comb begin
    scaled = acc_q >>> rk4o_pkg::FRAC_BITS;
    top    = scaled[rk4o_pkg::PROD_W-1:rk4o_pkg::W-1];
    rsp_o.done = done_q;
    rsp_o.clip = !((&top) || !(|top));
    if (rsp_o.clip) begin
      rsp_o.res = scaled[rk4o_pkg::PROD_W-1] ? rk4o_pkg::W_MIN : rk4o_pkg::W_MAX;
    end else begin
      rsp_o.res = scaled[rk4o_pkg::W-1:0];
    end
  end

endmodule

>>> rtl/rk4o_div6.sv
// Floor division of two nonnegative wide sums by six, one hex digit per cycle in each lane.
module rk4o_div6 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rk4o_pkg::div_req_t req_i,
  output rk4o_pkg::div_rsp_t rsp_o
);

  localparam int DIGITS  = rk4o_pkg::SUM_W / 4;
  localparam int CNT_W   = $clog2(DIGITS);
  localparam int DIVISOR = 6;
  // 43/256 slightly exceeds 1/6; the error stays below one for partial remainders under 96.
  localparam int RECIP   = 43;

  typedef struct packed {
    logic [3:0] q;
    logic [2:0] rem;
  } digit_t;

  logic                         busy_q;
  logic                         done_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [rk4o_pkg::SUM_W-1:0]   up_q, uv_q, qp_q, qv_q;
  logic [2:0]                   rp_q, rv_q;
  digit_t                       dp, dv;

  // One quotient digit from the running remainder and the next dividend digit.
  function automatic digit_t div_digit(input logic [2:0] r, input logic [3:0] n);
    logic [6:0]  part;
    logic [12:0] prod;
    digit_t      d;
    part  = {r, n};
    prod  = 13'(part) * 13'(RECIP);
    d.q   = prod[11:8];
    d.rem = 3'(part - 7'(d.q) * 7'(DIVISOR));
    return d;
  endfunction

  always_comb begin
    dp = div_digit(rp_q, up_q[rk4o_pkg::SUM_W-1 -: 4]);
    dv = div_digit(rv_q, uv_q[rk4o_pkg::SUM_W-1 -: 4]);
  end

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIGITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift the dividends out and the quotient digits in, most significant first.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      up_q <= req_i.u_pos;
      uv_q <= req_i.u_vel;
      rp_q <= '0;
      rv_q <= '0;
    end else if (busy_q) begin
      up_q <= up_q << 4;
      uv_q <= uv_q << 4;
      qp_q <= {qp_q[rk4o_pkg::SUM_W-5:0], dp.q};
      qv_q <= {qv_q[rk4o_pkg::SUM_W-5:0], dv.q};
      rp_q <= dp.rem;
      rv_q <= dv.rem;
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.q_pos = qp_q;
  assign rsp_o.q_vel = qv_q;

endmodule

>>> test/tb_rk4_damped_oscillator_step_unit.sv
module tb_rk4_damped_oscillator_step_unit;
  import rk4o_pkg::*;

  // Item kinds carried in s_axis_tuser.
  typedef enum logic {
    KIND_LOAD,
    KIND_STEP
  } osc_kind_e;

  typedef struct packed {
    osc_kind_e kind;
    word_t     ld_pos;
    word_t     ld_vel;
  } osc_item_t;

  typedef struct packed {
    word_t pos;
    word_t vel;
    logic  sat;
  } osc_state_t;

  localparam longint WORD_HI = 64'sd140737488355327;
  localparam longint WORD_LO = -WORD_HI - 64'sd1;
  localparam int     PHASE_ITEMS = 155;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata = '0;    // load_position, load_velocity
  logic                 s_axis_tuser = 1'b0;  // kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;         // position, velocity
  logic                 m_axis_tuser;         // saturated
  logic                 cfg_we_i = 1'b0;
  logic [1:0]           cfg_idx_i = '0;
  logic [W-1:0]         cfg_data_i = '0;

  // Shadow copy of the coefficients and the oscillator state.
  longint       drive_c = 0;
  longint       stiff_c = 0;
  longint       damp_c = 0;
  logic [H_W-1:0] step_h = H_RESET;
  longint       osc_pos = 0;
  longint       osc_vel = 0;
  bit           clip_seen;

  osc_item_t    queued_items[$];
  osc_state_t   predicted_states[$];
  osc_item_t    next_item;
  osc_state_t   want;
  bit           item_taken = 1'b0;
  int           src_idle_pct = 17;
  int           sink_idle_pct = 49;
  int           fail_count = 0;

  rk4_damped_oscillator_step_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Clip to the 48-bit signed range and remember that a clip happened.
  function automatic longint clip48(longint v);
    if (v > WORD_HI) begin
      clip_seen = 1'b1;
      return WORD_HI;
    end
    if (v < WORD_LO) begin
      clip_seen = 1'b1;
      return WORD_LO;
    end
    return v;
  endfunction

  // Fixed-point product, rounded toward minus infinity, then clipped.
  function automatic longint fx_mul(longint x, longint y);
    logic signed [127:0] xe, ye, p;
    xe = x;
    ye = y;
    p = (xe * ye) >>> FRAC_BITS;
    if (p > WORD_HI) begin
      clip_seen = 1'b1;
      return WORD_HI;
    end
    if (p < WORD_LO) begin
      clip_seen = 1'b1;
      return WORD_LO;
    end
    return longint'(p);
  endfunction

  // Acceleration a - c*z - b*y, summed exactly and clipped once.
  function automatic longint accel(longint y, longint z);
    longint cz, by;
    cz = fx_mul(damp_c, z);
    by = fx_mul(stiff_c, y);
    return clip48(drive_c - cz - by);
  endfunction

  // Division by six rounded toward minus infinity.
  function automatic longint floor_div6(longint s);
    longint q;
    q = s / 6;
    if (s < 0 && (s % 6) != 0) q = q - 1;
    return q;
  endfunction

  // Apply one item to the shadow state and return the state it should report.
  function automatic osc_state_t rk4_update(osc_item_t it);
    osc_state_t r;
    longint hv, y, z, k1, l1, k2, l2, k3, l3, k4, l4, ya, za;
    clip_seen = 1'b0;
    if (it.kind == KIND_LOAD) begin
      osc_pos = it.ld_pos;
      osc_vel = it.ld_vel;
    end else begin
      hv = step_h;
      y = osc_pos;
      z = osc_vel;
      k1 = fx_mul(hv, z);
      l1 = fx_mul(hv, accel(y, z));
      ya = clip48(y + (k1 >>> 1));
      za = clip48(z + (l1 >>> 1));
      k2 = fx_mul(hv, za);
      l2 = fx_mul(hv, accel(ya, za));
      ya = clip48(y + (k2 >>> 1));
      za = clip48(z + (l2 >>> 1));
      k3 = fx_mul(hv, za);
      l3 = fx_mul(hv, accel(ya, za));
      ya = clip48(y + k3);
      za = clip48(z + l3);
      k4 = fx_mul(hv, za);
      l4 = fx_mul(hv, accel(ya, za));
      osc_pos = clip48(y + floor_div6(k1 + 2 * k2 + 2 * k3 + k4));
      osc_vel = clip48(z + floor_div6(l1 + 2 * l2 + 2 * l3 + l4));
    end
    r.pos = osc_pos[W-1:0];
    r.vel = osc_vel[W-1:0];
    r.sat = clip_seen;
    return r;
  endfunction

  // Print one line per failure and count every one.
  task automatic note_failure(string msg);
    fail_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // A random word: full range, an extreme, or a modest value around zero.
  function automatic word_t pick_word();
    word_t w;
    w = word_t'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0, 1: return w;
      2: begin
        case ($urandom_range(0, 4))
          0: return W_MAX;
          1: return W_MIN;
          2: return '0;
          3: return word_t'(1);
          default: return word_t'(-1);
        endcase
      end
      default: return w >>> 12;
    endcase
  endfunction

  task automatic push_item(osc_kind_e kind, word_t p, word_t v);
    osc_item_t it;
    it.kind   = kind;
    it.ld_pos = p;
    it.ld_vel = v;
    queued_items.push_back(it);
  endtask

  // Wait until no transaction is queued, offered or outstanding.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (queued_items.size() != 0 || s_axis_tvalid || predicted_states.size() != 0);
  endtask

  // Write all four registers while the unit is idle.
  task automatic load_settings(word_t drive, word_t stiff, word_t damp, logic [W-1:0] h_word);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_DRIVE;
    cfg_data_i <= drive;
    @(negedge clk_i);
    cfg_idx_i <= CFG_STIFF;
    cfg_data_i <= stiff;
    @(negedge clk_i);
    cfg_idx_i <= CFG_DAMP;
    cfg_data_i <= damp;
    @(negedge clk_i);
    cfg_idx_i <= CFG_STEP;
    cfg_data_i <= h_word;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    drive_c = drive;
    stiff_c = stiff;
    damp_c = damp;
    step_h = h_word[H_W-1:0];
  endtask

  // Input driver: offer the next queued item once the current one is taken.
  always @(negedge clk_i) begin : feed_items
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || item_taken) begin
      item_taken = 1'b0;
      if (queued_items.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        next_item = queued_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {next_item.ld_vel, next_item.ld_pos};
        s_axis_tuser <= next_item.kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output back-pressure.
  always @(negedge clk_i) begin : drive_ready
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Each accepted input transaction advances the shadow oscillator.
  always @(posedge clk_i) begin : take_items
    osc_item_t seen;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      item_taken = 1'b1;
      seen.kind   = osc_kind_e'(s_axis_tuser);
      seen.ld_pos = s_axis_tdata[W-1:0];
      seen.ld_vel = s_axis_tdata[2*W-1:W];
      predicted_states.push_back(rk4_update(seen));
    end
  end

  // Compare each output transaction with the oldest prediction.
  always @(posedge clk_i) begin : check_states
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (predicted_states.size() == 0) begin
        note_failure($sformatf("unexpected result %h sat %b", m_axis_tdata, m_axis_tuser));
      end else begin
        want = predicted_states.pop_front();
        if (m_axis_tdata[W-1:0] !== want.pos)
          note_failure($sformatf("position %h, expected %h", m_axis_tdata[W-1:0], want.pos));
        if (m_axis_tdata[2*W-1:W] !== want.vel)
          note_failure($sformatf("velocity %h, expected %h", m_axis_tdata[2*W-1:W], want.vel));
        if (m_axis_tuser !== want.sat)
          note_failure($sformatf("saturated %b, expected %b", m_axis_tuser, want.sat));
      end
    end
  end

  // Stimulus sequence.
  initial begin : run_stimulus
    int n, steps;
    word_t d, s, c;
    logic [H_W-1:0] h33;
    logic [W-1:0] hw;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset coefficients: a step from rest, then three loads, each followed by a step.
    push_item(KIND_STEP, pick_word(), pick_word());
    push_item(KIND_LOAD, W_MAX, W_MIN);
    push_item(KIND_STEP, '0, '0);
    push_item(KIND_LOAD, W_MIN, W_MAX);
    push_item(KIND_STEP, W_MAX, W_MAX);
    push_item(KIND_LOAD, '0, '0);
    push_item(KIND_STEP, W_MIN, W_MIN);

    // Largest coefficients with a step size written above its 33 bits.
    load_settings(W_MAX, W_MAX, W_MAX, {W{1'b1}});
    push_item(KIND_LOAD, W_MAX, W_MAX);
    push_item(KIND_STEP, '0, '0);
    push_item(KIND_LOAD, W_MIN, W_MIN);
    push_item(KIND_STEP, '0, '0);
    push_item(KIND_LOAD, word_t'(1), word_t'(-1));
    push_item(KIND_STEP, '0, '0);
    push_item(KIND_STEP, '0, '0);

    // Smallest coefficients with a zero step: the state must hold.
    load_settings(W_MIN, W_MIN, W_MIN, '0);
    push_item(KIND_LOAD, pick_word(), pick_word());
    push_item(KIND_STEP, '0, '0);
    push_item(KIND_STEP, '0, '0);
    push_item(KIND_LOAD, W_MAX, W_MIN);
    push_item(KIND_STEP, '0, '0);

    // Unit step on a plain damped spring.
    load_settings('0, word_t'(64'sd1 <<< 32), word_t'(64'sd1 <<< 31), W'(64'd1 << 32));
    push_item(KIND_LOAD, word_t'(64'sd1 <<< 32), '0);
    push_item(KIND_STEP, '0, '0);
    push_item(KIND_STEP, '0, '0);
    push_item(KIND_STEP, '0, '0);

    // Random phases: a load followed by a run of steps, with some noise.
    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 4) begin
        src_idle_pct = 17;
        sink_idle_pct = 49;
      end else if (ph < 7) begin
        src_idle_pct = 49;
        sink_idle_pct = 17;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      if ($urandom_range(0, 3) == 0) h33 = {1'($urandom_range(0, 1)), $urandom};
      else h33 = H_W'($urandom_range(1, 1 << 26));
      hw = {15'($urandom), h33};
      d = word_t'({$urandom, $urandom});
      s = word_t'({$urandom, $urandom});
      c = word_t'({$urandom, $urandom});
      if (ph == 2) load_settings(W_MAX, W_MAX, W_MAX, W'(64'd1 << 32));
      else if (ph == 5) load_settings(W_MIN, W_MIN, W_MIN, {W{1'b1}});
      else if (ph == 8) load_settings(d, s, c, hw);
      else load_settings(d >>> 10, s >>> 14, c >>> 16, hw);
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 85) begin
          push_item(KIND_LOAD, pick_word(), pick_word());
          steps = $urandom_range(1, 12);
          repeat (steps) push_item(KIND_STEP, word_t'({$urandom, $urandom}),
                                   word_t'({$urandom, $urandom}));
          n += steps + 1;
        end else begin
          push_item(osc_kind_e'($urandom_range(0, 1)), pick_word(), pick_word());
          n++;
        end
      end
    end

    // Drain, then allow for a step still in flight before judging.
    wait_idle();
    repeat (200) @(posedge clk_i);
    if (predicted_states.size() != 0)
      note_failure($sformatf("%0d results never arrived", predicted_states.size()));
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #15_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
